// ----- hw/rtl/rpsg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsg_pkg
// Shared types, codes and helpers of the replay protected start gate.
// ----------------------------------------------------------------------------
package rpsg_pkg;

  localparam int ID_W     = 32;
  localparam int TIME_W   = 64;
  localparam int WINDOW_W = 63;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int SERIAL_W = 8;

  localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MISSION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRESHNESS_WINDOW = 2'd1;

  localparam logic [ID_W-1:0]     TARGET_MISSION_RST   = 32'd1;
  localparam logic [WINDOW_W-1:0] FRESHNESS_WINDOW_RST = 63'd1000000000;
  localparam logic [TIME_W-1:0]   NO_TIME              = {TIME_W{1'b1}};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   mission;
    logic [ID_W-1:0]   session;
    logic [ID_W-1:0]   seq_no;
    logic [ID_W-1:0]   epoch;
    logic [TIME_W-1:0] time_ns;
    logic              running;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]   current_epoch;
    logic [ID_W-1:0]   pend_mission;
    logic [ID_W-1:0]   pend_session;
    logic [ID_W-1:0]   pend_sequence;
    logic [ID_W-1:0]   pend_epoch;
    logic [TIME_W-1:0] context_time;
    logic              used;
  } gate_state_t;

  typedef struct packed {
    logic [ID_W-1:0]     target_mission;
    logic [WINDOW_W-1:0] freshness_window;
  } cfg_t;

  // Candidate is newer when the low-byte difference lies in the lower half, excluding zero.
  function automatic logic serial_newer(input logic [ID_W-1:0] cand,
                                        input logic [ID_W-1:0] cur);
    logic [SERIAL_W-1:0] d;
    d = cand[SERIAL_W-1:0] - cur[SERIAL_W-1:0];
    return (d != '0) && !d[SERIAL_W-1];
  endfunction

endpackage

// ----- hw/rtl/rpsg_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsg_cfg_regs
// Configuration register file: target mission and freshness window.
// ----------------------------------------------------------------------------
module rpsg_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rpsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpsg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rpsg_pkg::cfg_t                     cfg
);

  rpsg_pkg::cfg_t cfg_r;
  rpsg_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        rpsg_pkg::CFG_TARGET_MISSION: begin
          cfg_nxt.target_mission = cfg_data[rpsg_pkg::ID_W-1:0];
        end
        rpsg_pkg::CFG_FRESHNESS_WINDOW: begin
          cfg_nxt.freshness_window = cfg_data[rpsg_pkg::WINDOW_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_mission   <= rpsg_pkg::TARGET_MISSION_RST;
      cfg_r.freshness_window <= rpsg_pkg::FRESHNESS_WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hw/rtl/rpsg_decide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsg_decide
// Evaluates one word against the gate state and produces the grant and the
// next gate state.
// ----------------------------------------------------------------------------
module rpsg_decide (
  input  rpsg_pkg::item_t       item,
  input  rpsg_pkg::gate_state_t st,
  input  rpsg_pkg::cfg_t        cfg,
  output rpsg_pkg::gate_state_t st_nxt,
  output logic                  granted
);

  logic                        no_ctx;
  logic                        time_back;
  logic                        newer_ok;
  logic                        obs_ok;
  logic                        acc_ok;
  logic [rpsg_pkg::TIME_W-1:0] elapsed;
  logic                        fresh;

  assign no_ctx    = st.context_time[rpsg_pkg::TIME_W-1];
  assign time_back = item.time_ns < st.context_time;
  assign elapsed   = item.time_ns - st.context_time;
  assign fresh     = elapsed < {1'b0, cfg.freshness_window};

  assign newer_ok = (item.session == st.pend_session) ?
                    rpsg_pkg::serial_newer(item.seq_no, st.pend_sequence) :
                    rpsg_pkg::serial_newer(item.session, st.pend_session);

  assign obs_ok = !item.time_ns[rpsg_pkg::TIME_W-1] && (item.mission != '0) &&
                  (item.session != '0) && (item.seq_no != '0) &&
                  (item.epoch != '0) && (item.epoch == st.current_epoch) &&
                  !st.used && (no_ctx || (!time_back && newer_ok));

  assign acc_ok = !st.used && (item.mission != '0) &&
                  (item.mission == cfg.target_mission) &&
                  (st.pend_mission == item.mission) && (st.pend_session != '0) &&
                  (st.pend_sequence != '0) && (st.pend_epoch == st.current_epoch) &&
                  !no_ctx && !item.time_ns[rpsg_pkg::TIME_W-1] && !time_back && fresh;

  always_comb begin
    st_nxt  = st;
    granted = 1'b0;
    case (item.op)
      rpsg_pkg::OP_OBSERVE: begin
        if (obs_ok) begin
          st_nxt.pend_mission  = item.mission;
          st_nxt.pend_session  = item.session;
          st_nxt.pend_sequence = item.seq_no;
          st_nxt.pend_epoch    = item.epoch;
          st_nxt.context_time  = item.time_ns;
          granted              = 1'b1;
        end
      end
      rpsg_pkg::OP_ACCEPT: begin
        if (item.running) begin
          st_nxt.pend_mission  = '0;
          st_nxt.pend_session  = '0;
          st_nxt.pend_sequence = '0;
          st_nxt.pend_epoch    = '0;
          st_nxt.context_time  = rpsg_pkg::NO_TIME;
        end else if (acc_ok) begin
          st_nxt.used = 1'b1;
          granted     = 1'b1;
        end
      end
      rpsg_pkg::OP_RESTART: begin
        if (item.epoch != '0) begin
          st_nxt.current_epoch = item.epoch;
          st_nxt.pend_mission  = '0;
          st_nxt.pend_session  = '0;
          st_nxt.pend_sequence = '0;
          st_nxt.pend_epoch    = '0;
          st_nxt.context_time  = rpsg_pkg::NO_TIME;
          st_nxt.used          = 1'b0;
          granted              = 1'b1;
        end
      end
      default: begin
        st_nxt  = st;
        granted = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/replay_protected_start_gate_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replay_protected_start_gate_core
// One-shot start gate with replay protection: observe, accept and restart
// words, one grant word out for each word in.
//
//   Channel | Direction | Handshake           | Payload
//   in      | input     | in_valid/in_ready   | op, ids, epoch, time, running
//   out     | output    | out_valid/out_ready | granted
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A word is registered in the input stage and its grant in the output register
// when the word advances, and one word per cycle is sustained while the output
// is not stalled.
// Synchronous reset leaves the gate unarmed with epoch zero and no pending context.
// A stalled output holds the input register, and in_ready drops only when both
// stages are full.
// ----------------------------------------------------------------------------
module replay_protected_start_gate_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rpsg_pkg::OP_W-1:0]        in_op,
  input  logic [rpsg_pkg::ID_W-1:0]        in_mission_id,
  input  logic [rpsg_pkg::ID_W-1:0]        in_session_id,
  input  logic [rpsg_pkg::ID_W-1:0]        in_sequence_req,
  input  logic [rpsg_pkg::ID_W-1:0]        in_epoch,
  input  logic signed [rpsg_pkg::TIME_W-1:0] in_time_ns,
  input  logic                             in_mission_running,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_granted,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rpsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpsg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rpsg_pkg::cfg_t        cfg;
  rpsg_pkg::item_t       item_r;
  rpsg_pkg::gate_state_t st_r;
  rpsg_pkg::gate_state_t st_nxt;
  logic                  item_valid_r;
  logic                  out_valid_r;
  logic                  granted_r;
  logic                  granted_nxt;
  logic                  adv;

  rpsg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpsg_decide u_decide (
    .item    (item_r),
    .st      (st_r),
    .cfg     (cfg),
    .st_nxt  (st_nxt),
    .granted (granted_nxt)
  );

  assign adv         = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready    = !item_valid_r || adv;
  assign out_valid   = out_valid_r;
  assign out_granted = granted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.op       <= in_op;
      item_r.mission  <= in_mission_id;
      item_r.session  <= in_session_id;
      item_r.seq_no   <= in_sequence_req;
      item_r.epoch    <= in_epoch;
      item_r.time_ns  <= in_time_ns;
      item_r.running  <= in_mission_running;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.current_epoch <= '0;
      st_r.pend_mission  <= '0;
      st_r.pend_session  <= '0;
      st_r.pend_sequence <= '0;
      st_r.pend_epoch    <= '0;
      st_r.context_time  <= rpsg_pkg::NO_TIME;
      st_r.used          <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      granted_r <= granted_nxt;
    end
  end

  // A used grant can only exist inside an armed epoch.
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r.used |-> (st_r.current_epoch != '0))
    else $error("used flag set while gate unarmed");

  // A granted accept marks the epoch as used.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (item_r.op == rpsg_pkg::OP_ACCEPT) && granted_nxt) |=> st_r.used)
    else $error("accept granted without setting used flag");

  // A taken restart clears the pending context and the used flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (item_r.op == rpsg_pkg::OP_RESTART) && (item_r.epoch != '0))
    |=> ((st_r.context_time == rpsg_pkg::NO_TIME) && !st_r.used))
    else $error("restart did not clear state");

  // Backpressure on the input only arises with a word held in the input stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (item_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

endmodule
